>>> sv/ngc_pkg.sv
// ----------------------------------------------------------------------------
// ngc_pkg: shared definitions for the normalized gear chunker
// Register codes, field widths, result record and the gear table ROM,
// which is built at elaboration from the MD5 digest of 64 copies of each
// byte value.
// ----------------------------------------------------------------------------
package ngc_pkg;

	// Field widths fixed by the register map and the result format
	localparam int OUT_W     = 18;
	localparam int MIN_W     = 18;
	localparam int MAX_W     = 18;
	localparam int EXP_W     = 17;
	localparam int MASK_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int GEAR_W    = 64;
	localparam int GEAR_DEPTH = 256;

	// Parameter defaults
	localparam int LENGTH_BITS_DEF   = 24;
	localparam int POSITION_BITS_DEF = 17;

	// Register reset values
	localparam logic [MIN_W-1:0]  MIN_SIZE_RST      = MIN_W'(2048);
	localparam logic [MAX_W-1:0]  MAX_SIZE_RST      = MAX_W'(65536);
	localparam logic [EXP_W-1:0]  EXPECTED_SIZE_RST = EXP_W'(8192);
	localparam logic [MASK_W-1:0] MASK_STRICT_RST   = 64'h0000_d903_1353_0000;
	localparam logic [MASK_W-1:0] MASK_LOOSE_RST    = 64'h0000_d901_0353_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_SIZE      = 3'd0,
		CFG_MAX_SIZE      = 3'd1,
		CFG_EXPECTED_SIZE = 3'd2,
		CFG_MASK_STRICT   = 3'd3,
		CFG_MASK_LOOSE    = 3'd4
	} cfg_idx_t;

	// One result of the scan stage
	typedef struct packed {
		logic             emit;
		logic [OUT_W-1:0] len;
		logic             cut;
	} result_t;

	// MD5 round constants
	localparam logic [31:0] MD_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// MD5 rotate amounts, four per round
	localparam logic [4:0] MD_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [31:0] md_rotl(logic [31:0] x, logic [4:0] s);
		logic [5:0] rs;
		rs = 6'd32 - {1'b0, s};
		return (x << s) | (x >> rs);
	endfunction

	// One MD5 compression; state word k sits at st[32*k +: 32]
	function automatic logic [127:0] md_block(logic [127:0] st, logic [511:0] m);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] f;
		logic [31:0] t;
		int          g;
		a = st[31:0];
		b = st[63:32];
		c = st[95:64];
		d = st[127:96];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d);
				g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c);
				g = (5 * i + 1) & 15;
			end else if (i < 48) begin
				f = b ^ c ^ d;
				g = (3 * i + 5) & 15;
			end else begin
				f = c ^ (b | ~d);
				g = (7 * i) & 15;
			end
			t = d;
			d = c;
			c = b;
			b = b + md_rotl(a + f + MD_K[i] + m[g*32 +: 32], MD_S[((i >> 4) << 2) | (i & 3)]);
			a = t;
		end
		return {st[127:96] + d, st[95:64] + c, st[63:32] + b, st[31:0] + a};
	endfunction

	// Low 64 bits (little-endian) of MD5 over 64 copies of one byte value
	function automatic logic [GEAR_W-1:0] gear_entry(logic [7:0] v);
		logic [127:0] st;
		logic [511:0] m;
		st = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
		m  = {64{v}};
		st = md_block(st, m);
		m  = '0;
		m[31:0]        = 32'h0000_0080;
		m[14*32 +: 32] = 32'd512;
		st = md_block(st, m);
		return st[63:0];
	endfunction

	function automatic logic [GEAR_DEPTH*GEAR_W-1:0] gear_rom_build();
		logic [GEAR_DEPTH*GEAR_W-1:0] rom;
		rom = '0;
		for (int v = 0; v < GEAR_DEPTH; v++) begin
			rom[v*GEAR_W +: GEAR_W] = gear_entry(8'(v));
		end
		return rom;
	endfunction

	// Gear table, entry v at bits [64*v +: 64]
	localparam logic [GEAR_DEPTH*GEAR_W-1:0] GEAR_ROM = gear_rom_build();

endpackage

>>> sv/normalized_gear_chunker.sv
// ----------------------------------------------------------------------------
// normalized_gear_chunker: content-defined chunk boundary finder
// Streams the bytes of a buffer through a gear fingerprint and reports the
// chunk length chosen for that buffer.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle unless the input is stalled: a byte
// goes into an input register (gear ROM lookup and length limits computed
// on the way), then one 64-bit shift-add plus mask test decides the cut and
// loads the result register (result_valid). The loop that sets the rate is
// the fingerprint register feeding its own adder. Only result_stall holds
// up the input side; a byte that is not the last one of a chunk still
// waits while a stalled result is pending. Bytes after a chunk's result,
// and bytes without first_byte while idle, are dropped silently. Registers
// are to be written only between buffers; the block does not enforce this.
// ----------------------------------------------------------------------------
module normalized_gear_chunker #(
	parameter int LENGTH_BITS   = ngc_pkg::LENGTH_BITS_DEF,
	parameter int POSITION_BITS = ngc_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ngc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ngc_pkg::CFG_W-1:0]         cfg_data,
	// byte items
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              first_byte,
	input  logic [LENGTH_BITS-1:0]            buffer_len,
	// result items
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [ngc_pkg::OUT_W-1:0]         chunk_length,
	output logic                              hash_cut
);

	localparam int CW0 = (LENGTH_BITS > ngc_pkg::MAX_W) ? LENGTH_BITS : ngc_pkg::MAX_W;
	localparam int CW  = (CW0 > POSITION_BITS + 1) ? CW0 : POSITION_BITS + 1;
	localparam logic [CW-1:0] POS_CAP = CW'(1) << POSITION_BITS;

	logic [ngc_pkg::MIN_W-1:0]  min_size_q;
	logic [ngc_pkg::MAX_W-1:0]  max_size_q;
	logic [ngc_pkg::EXP_W-1:0]  expected_size_q;
	logic [ngc_pkg::MASK_W-1:0] mask_strict_q;
	logic [ngc_pkg::MASK_W-1:0] mask_loose_q;

	logic                       valid_s1;
	logic                       first_s1;
	logic                       short_s1;
	logic [ngc_pkg::OUT_W-1:0]  len_s1;
	logic [POSITION_BITS:0]     limit_s1;
	logic [ngc_pkg::EXP_W-1:0]  normal_s1;
	logic [ngc_pkg::GEAR_W-1:0] gear_s1;

	logic                       res_valid_q;
	logic [ngc_pkg::OUT_W-1:0]  res_len_q;
	logic                       res_cut_q;

	logic [CW-1:0]              n_ext;
	logic [CW-1:0]              lim_wide;
	logic [CW-1:0]              lim_cap;
	logic [CW-1:0]              nrm_wide;
	logic                       advance;
	logic                       in_take;
	ngc_pkg::result_t           res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q      <= ngc_pkg::MIN_SIZE_RST;
			max_size_q      <= ngc_pkg::MAX_SIZE_RST;
			expected_size_q <= ngc_pkg::EXPECTED_SIZE_RST;
			mask_strict_q   <= ngc_pkg::MASK_STRICT_RST;
			mask_loose_q    <= ngc_pkg::MASK_LOOSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ngc_pkg::CFG_MIN_SIZE:      min_size_q      <= cfg_data[ngc_pkg::MIN_W-1:0];
				ngc_pkg::CFG_MAX_SIZE:      max_size_q      <= cfg_data[ngc_pkg::MAX_W-1:0];
				ngc_pkg::CFG_EXPECTED_SIZE: expected_size_q <= cfg_data[ngc_pkg::EXP_W-1:0];
				ngc_pkg::CFG_MASK_STRICT:   mask_strict_q   <= cfg_data;
				ngc_pkg::CFG_MASK_LOOSE:    mask_loose_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the scan stage moves whenever the result slot is free or drains
	assign advance    = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign in_take    = item_valid && !item_stall;

	// Buffer limits from the length on the first byte
	always_comb begin
		n_ext    = CW'(buffer_len);
		lim_wide = (n_ext < CW'(max_size_q)) ? n_ext : CW'(max_size_q);
		lim_cap  = (lim_wide > POS_CAP) ? POS_CAP : lim_wide;
		nrm_wide = (n_ext < CW'(expected_size_q)) ? n_ext : CW'(expected_size_q);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			first_s1  <= first_byte;
			short_s1  <= n_ext <= CW'(min_size_q);
			len_s1    <= ngc_pkg::OUT_W'(buffer_len);
			limit_s1  <= lim_cap[POSITION_BITS:0];
			normal_s1 <= nrm_wide[ngc_pkg::EXP_W-1:0];
			gear_s1   <= ngc_pkg::GEAR_ROM[{data_byte, 6'd0} +: ngc_pkg::GEAR_W];
		end
	end

	ngc_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (valid_s1 && advance),
		.first        (first_s1),
		.short_buf    (short_s1),
		.short_len    (len_s1),
		.start_limit  (limit_s1),
		.start_normal (normal_s1),
		.gear         (gear_s1),
		.mask_strict  (mask_strict_q),
		.mask_loose   (mask_loose_q),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.emit) begin
			res_len_q <= res.len;
			res_cut_q <= res.cut;
		end
	end

	assign result_valid = res_valid_q;
	assign chunk_length = res_len_q;
	assign hash_cut     = res_cut_q;

endmodule

>>> sv/ngc_scan.sv
// ----------------------------------------------------------------------------
// ngc_scan: rolling gear fingerprint and cut decision
// Holds the per-buffer scan state and decides, for one registered item,
// whether it ends the chunk and with which length.
// ----------------------------------------------------------------------------
module ngc_scan #(
	parameter int POSITION_BITS = ngc_pkg::POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          first,
	input  logic                          short_buf,
	input  logic [ngc_pkg::OUT_W-1:0]     short_len,
	input  logic [POSITION_BITS:0]        start_limit,
	input  logic [ngc_pkg::EXP_W-1:0]     start_normal,
	input  logic [ngc_pkg::GEAR_W-1:0]    gear,
	input  logic [ngc_pkg::MASK_W-1:0]    mask_strict,
	input  logic [ngc_pkg::MASK_W-1:0]    mask_loose,
	output ngc_pkg::result_t              res
);

	localparam int NCW = (POSITION_BITS > ngc_pkg::EXP_W) ? POSITION_BITS : ngc_pkg::EXP_W;

	logic [ngc_pkg::GEAR_W-1:0]  fp_q;
	logic [POSITION_BITS-1:0]    pos_q;
	logic [POSITION_BITS:0]      limit_q;
	logic [ngc_pkg::EXP_W-1:0]   normal_q;
	logic                        scan_q;

	logic [ngc_pkg::GEAR_W-1:0]  fp_base;
	logic [POSITION_BITS-1:0]    pos_base;
	logic [POSITION_BITS:0]      lim;
	logic [ngc_pkg::EXP_W-1:0]   nrm;
	logic                        active;
	logic [ngc_pkg::GEAR_W-1:0]  fp_new;
	logic [ngc_pkg::MASK_W-1:0]  mask;
	logic [POSITION_BITS:0]      pos_inc;
	logic                        scan_next;

	// Restart state on the first byte of a buffer
	always_comb begin
		fp_base  = first ? '0 : fp_q;
		pos_base = first ? '0 : pos_q;
		lim      = first ? start_limit : limit_q;
		nrm      = first ? start_normal : normal_q;
		active   = first ? !short_buf : scan_q;
	end

	// Roll the fingerprint and pick the mask by position
	always_comb begin
		fp_new  = (fp_base << 1) + gear;
		mask    = (NCW'(pos_base) < NCW'(nrm)) ? mask_strict : mask_loose;
		pos_inc = {1'b0, pos_base} + 1'b1;
	end

	// Decide the cut
	always_comb begin
		res       = '0;
		scan_next = 1'b0;
		priority if (first && short_buf) begin
			res.emit = 1'b1;
			res.len  = short_len;
		end else if (!active) begin
			scan_next = 1'b0;
		end else if (lim == '0) begin
			res.emit = 1'b1;
		end else if ((fp_new & mask) == '0) begin
			res.emit = 1'b1;
			res.len  = ngc_pkg::OUT_W'(pos_base);
			res.cut  = 1'b1;
		end else if (pos_inc >= lim) begin
			res.emit = 1'b1;
			res.len  = ngc_pkg::OUT_W'(lim);
		end else begin
			scan_next = 1'b1;
		end
	end

	// Advance scan state once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q     <= '0;
			pos_q    <= '0;
			limit_q  <= '0;
			normal_q <= '0;
			scan_q   <= 1'b0;
		end else if (fire) begin
			fp_q     <= fp_new;
			pos_q    <= pos_inc[POSITION_BITS-1:0];
			limit_q  <= lim;
			normal_q <= nrm;
			scan_q   <= scan_next;
		end
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the normalized gear chunker
// Streams byte items with random gaps on both channels into the chunker,
// predicts each chunk decision with an independent gear fingerprint model
// (its own MD5-derived table) and compares every result item in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LEN_W          = ngc_pkg::LENGTH_BITS_DEF;
	localparam int POSITION_CAP   = 1 << ngc_pkg::POSITION_BITS_DEF;
	localparam int N_ITEMS        = 500;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int TIMEOUT_CYCLES = 200_000;
	localparam logic [ngc_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

	// One expected chunk decision
	typedef struct packed {
		logic [ngc_pkg::OUT_W-1:0] len;
		logic                      cut;
	} cut_rec_t;

	// One pending register write
	typedef struct {
		logic [ngc_pkg::CFG_IDX_W-1:0] idx;
		logic [ngc_pkg::CFG_W-1:0]     val;
	} reg_write_t;

	// Gear fingerprint chunker: mirrors registers and scan state, and
	// keeps the chunk decisions still to come out of the block.
	class gear_cutter;
		bit [63:0]               gear [256];
		bit [31:0]               md_k [64];
		int                      md_rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		                                        4, 11, 16, 23, 6, 10, 15, 21};
		bit [31:0]               md_st [4];
		bit [31:0]               md_m [16];
		bit [ngc_pkg::MIN_W-1:0] min_size;
		bit [ngc_pkg::MAX_W-1:0] max_size;
		bit [ngc_pkg::EXP_W-1:0] exp_size;
		bit [63:0]               mask_strict;
		bit [63:0]               mask_loose;
		bit [63:0]               fp;
		bit [31:0]               pos;
		bit [31:0]               lim;
		bit [31:0]               npt;
		bit                      busy;
		cut_rec_t                due_cuts [$];

		function new();
			real s;
			min_size    = 18'd2048;
			max_size    = 18'd65536;
			exp_size    = 17'd8192;
			mask_strict = 64'h0000_d903_1353_0000;
			mask_loose  = 64'h0000_d901_0353_0000;
			fp   = '0;
			pos  = '0;
			lim  = '0;
			npt  = '0;
			busy = 1'b0;
			// round constants: floor(|sin(i+1)| * 2^32)
			for (int i = 0; i < 64; i++) begin
				s = $sin(i + 1);
				if (s < 0.0) s = -s;
				md_k[i] = 32'(longint'($floor(s * 4294967296.0)));
			end
			// digest 64 copies of each byte value, keep the low 8 bytes
			for (int v = 0; v < 256; v++) begin
				md_st = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
				for (int i = 0; i < 16; i++) md_m[i] = {4{v[7:0]}};
				md_compress();
				for (int i = 0; i < 16; i++) md_m[i] = '0;
				md_m[0]  = 32'h80;
				md_m[14] = 32'd512;
				md_compress();
				gear[v] = {md_st[1], md_st[0]};
			end
		endfunction

		function bit [31:0] rotl(bit [31:0] x, int s);
			return (x << s) | (x >> (32 - s));
		endfunction

		function void md_compress();
			bit [31:0] a;
			bit [31:0] b;
			bit [31:0] c;
			bit [31:0] d;
			bit [31:0] f;
			bit [31:0] t;
			int        g;
			a = md_st[0];
			b = md_st[1];
			c = md_st[2];
			d = md_st[3];
			for (int i = 0; i < 64; i++) begin
				if (i < 16) begin
					f = (b & c) | (~b & d);
					g = i;
				end else if (i < 32) begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) % 16;
				end else if (i < 48) begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end else begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
				t = d;
				d = c;
				c = b;
				b = b + rotl(a + f + md_k[i] + md_m[g], md_rot[(i / 16) * 4 + i % 4]);
				a = t;
			end
			md_st[0] += a;
			md_st[1] += b;
			md_st[2] += c;
			md_st[3] += d;
		endfunction

		function void set_reg(logic [ngc_pkg::CFG_IDX_W-1:0] idx,
			logic [ngc_pkg::CFG_W-1:0] val);
			case (idx)
				ngc_pkg::CFG_MIN_SIZE:      min_size    = val[ngc_pkg::MIN_W-1:0];
				ngc_pkg::CFG_MAX_SIZE:      max_size    = val[ngc_pkg::MAX_W-1:0];
				ngc_pkg::CFG_EXPECTED_SIZE: exp_size    = val[ngc_pkg::EXP_W-1:0];
				ngc_pkg::CFG_MASK_STRICT:   mask_strict = val;
				ngc_pkg::CFG_MASK_LOOSE:    mask_loose  = val;
				default: ;
			endcase
		endfunction

		function void due(bit [31:0] len, bit cut);
			cut_rec_t r;
			r.len = len[ngc_pkg::OUT_W-1:0];
			r.cut = cut;
			due_cuts.push_back(r);
			busy = 1'b0;
		endfunction

		// Advance the scan by one accepted byte; return 1 unless the byte is dropped
		function bit take_byte(bit [7:0] b, bit first, bit [LEN_W-1:0] n);
			bit [63:0] msk;
			if (first) begin
				fp   = '0;
				pos  = '0;
				busy = 1'b0;
				if (n <= min_size) begin
					due(32'(n), 1'b0);
					return 1'b1;
				end
				lim = (n < max_size) ? 32'(n) : 32'(max_size);
				if (lim > POSITION_CAP) lim = POSITION_CAP;
				npt  = (n < exp_size) ? 32'(n) : 32'(exp_size);
				busy = 1'b1;
				if (lim == 0) begin
					due(0, 1'b0);
					return 1'b1;
				end
			end
			if (!busy) return 1'b0;
			fp  = (fp << 1) + gear[b];
			msk = (pos < npt) ? mask_strict : mask_loose;
			if ((fp & msk) == 0) begin
				due(pos, 1'b1);
				return 1'b1;
			end
			pos++;
			if (pos >= lim) due(lim, 1'b0);
			return 1'b1;
		endfunction

		// Compare one result item with the oldest decision due
		function string match_cut(logic [ngc_pkg::OUT_W-1:0] len, logic cut);
			cut_rec_t want;
			string    msg;
			if (due_cuts.size() == 0)
				return $sformatf("result with nothing due: chunk_length %0d hash_cut %b",
					len, cut);
			want = due_cuts.pop_front();
			msg  = "";
			if (len !== want.len)
				msg = $sformatf("chunk_length %0d, want %0d", len, want.len);
			if (cut !== want.cut) begin
				if (msg != "") msg = {msg, "; "};
				msg = {msg, $sformatf("hash_cut %b, want %b", cut, want.cut)};
			end
			return msg;
		endfunction

		function int pending_count();
			return due_cuts.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n       = 1'b0;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic [ngc_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [ngc_pkg::CFG_W-1:0]     cfg_data     = '0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	logic [7:0]                    data_byte    = '0;
	logic                          first_byte   = 1'b0;
	logic [LEN_W-1:0]              buffer_len   = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [ngc_pkg::OUT_W-1:0]     chunk_length;
	logic                          hash_cut;

	gear_cutter  cutter;
	reg_write_t  cfg_batch [$];
	int          send_idle_pct = 11;
	int          recv_idle_pct = 72;
	int          sent_items    = 0;
	int          errors        = 0;
	bit          hold_start    = 1'b0;
	int          hold_left     = 0;
	string       cut_msg;

	normalized_gear_chunker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.buffer_len   (buffer_len),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.chunk_length (chunk_length),
		.hash_cut     (hash_cut)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Check result items and drive the result stall, with long hold-offs on request
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			cut_msg = cutter.match_cut(chunk_length, hash_cut);
			if (cut_msg != "") report(cut_msg);
		end
		if (hold_start) begin
			hold_left  = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Offer one byte item, hold it until accepted, then feed the predictor
	task automatic send_byte(input logic [7:0] b, input logic first,
		input logic [LEN_W-1:0] n);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte  <= b;
		first_byte <= first;
		buffer_len <= n;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		void'(cutter.take_byte(b, first, n));
		sent_items++;
	endtask

	// Drop valid and wait until every decision due has come out
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (cutter.pending_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_write(input logic [ngc_pkg::CFG_IDX_W-1:0] idx,
		input logic [ngc_pkg::CFG_W-1:0] val);
		reg_write_t w;
		w.idx = idx;
		w.val = val;
		cfg_batch.push_back(w);
	endtask

	// Write queued registers back to back, then drop valid
	task automatic flush_cfg();
		reg_write_t w;
		while (cfg_batch.size() > 0) begin
			w = cfg_batch.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data  <= w.val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cutter.set_reg(w.idx, w.val);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] sparse_mask(int bits);
		logic [63:0] m;
		m = '0;
		repeat (bits) m[$urandom_range(0, 63)] = 1'b1;
		return m;
	endfunction

	// Pick sizes mostly small, sometimes at the extremes; masks with few bits
	task automatic random_cfg();
		logic [ngc_pkg::CFG_W-1:0] d;
		d = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: d[ngc_pkg::MIN_W-1:0] = '0;
			1: d[ngc_pkg::MIN_W-1:0] = '1;
			default: d[ngc_pkg::MIN_W-1:0] = ngc_pkg::MIN_W'($urandom_range(0, 30));
		endcase
		queue_write(ngc_pkg::CFG_MIN_SIZE, d);
		d = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: d[ngc_pkg::MAX_W-1:0] = '0;
			1: d[ngc_pkg::MAX_W-1:0] = '1;
			2: d[ngc_pkg::MAX_W-1:0] = ngc_pkg::MAX_W'($urandom_range(64, 131072));
			default: d[ngc_pkg::MAX_W-1:0] = ngc_pkg::MAX_W'($urandom_range(1, 120));
		endcase
		queue_write(ngc_pkg::CFG_MAX_SIZE, d);
		d = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: d[ngc_pkg::EXP_W-1:0] = '0;
			1: d[ngc_pkg::EXP_W-1:0] = '1;
			default: d[ngc_pkg::EXP_W-1:0] = ngc_pkg::EXP_W'($urandom_range(0, 150));
		endcase
		queue_write(ngc_pkg::CFG_EXPECTED_SIZE, d);
		queue_write(ngc_pkg::CFG_MASK_STRICT, sparse_mask($urandom_range(0, 6)));
		queue_write(ngc_pkg::CFG_MASK_LOOSE, sparse_mask($urandom_range(0, 4)));
	endtask

	// Send one buffer: mostly run to its decision, sometimes cut short or
	// preceded by stray bytes
	task automatic random_buffer(input bit allow_noise);
		logic [LEN_W-1:0] n;
		int               spn;
		int               count;
		if (allow_noise && $urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2))
				send_byte(8'($urandom()), 1'b0, LEN_W'($urandom()));
		case ($urandom_range(0, 9))
			0: n = LEN_W'($urandom());
			1: n = LEN_W'($urandom_range(0, cutter.min_size));
			default: n = LEN_W'($urandom_range(1, 200));
		endcase
		if (n <= cutter.min_size) begin
			spn = 1;
		end else begin
			spn = (n < cutter.max_size) ? int'(n) : int'(cutter.max_size);
			if (spn > 150) spn = 150;
			if (spn < 1) spn = 1;
		end
		if ($urandom_range(0, 7) == 0) count = int'($urandom_range(1, spn));
		else count = spn + int'($urandom_range(0, 2));
		send_byte(8'($urandom()), 1'b1, n);
		repeat (count - 1) send_byte(8'($urandom()), 1'b0, LEN_W'($urandom()));
	endtask

	// Main sequence: reset, directed cases, three random segments
	initial begin
		int  base;
		bit  fresh;
		cutter = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: empty and short buffers, stray byte, abandoned scans
		send_byte(8'h00, 1'b1, '0);
		send_byte(8'hFF, 1'b1, 24'd1);
		send_byte(8'h5A, 1'b0, 24'd0);
		send_byte(8'hA5, 1'b1, 24'd2048);
		send_byte(8'h3C, 1'b1, 24'd2049);
		send_byte(8'hC3, 1'b0, 24'd2049);
		send_byte(8'h81, 1'b1, '1);
		send_byte(8'h7E, 1'b1, 24'd2047);
		wait_drained();

		// zero limit, wide register data, unused register index
		queue_write(ngc_pkg::CFG_MIN_SIZE, 64'hFFFF_FFFF_FFFC_0003);
		queue_write(ngc_pkg::CFG_MAX_SIZE, '0);
		queue_write(ngc_pkg::CFG_EXPECTED_SIZE, '0);
		queue_write(ngc_pkg::CFG_MASK_STRICT, '0);
		queue_write(ngc_pkg::CFG_MASK_LOOSE, '0);
		queue_write(CFG_NO_REG, {$urandom(), $urandom()});
		flush_cfg();
		send_byte(8'h11, 1'b1, 24'd3);
		send_byte(8'h22, 1'b1, 24'd4);
		wait_drained();

		// zero mask: cut at position zero, then a dropped byte
		queue_write(ngc_pkg::CFG_MAX_SIZE, 64'd40);
		flush_cfg();
		send_byte(8'h33, 1'b1, 24'd9);
		send_byte(8'h44, 1'b0, 24'd9);
		wait_drained();

		// normal point beyond the limit: strict mask up to the limit
		queue_write(ngc_pkg::CFG_MIN_SIZE, '0);
		queue_write(ngc_pkg::CFG_MAX_SIZE, 64'd6);
		queue_write(ngc_pkg::CFG_EXPECTED_SIZE, 64'd128);
		queue_write(ngc_pkg::CFG_MASK_STRICT, '1);
		flush_cfg();
		send_byte(8'h00, 1'b1, 24'd100);
		repeat (5) send_byte(8'($urandom()), 1'b0, 24'd100);
		wait_drained();

		// switch to the loose mask at the normal point
		queue_write(ngc_pkg::CFG_MAX_SIZE, 64'd10);
		queue_write(ngc_pkg::CFG_EXPECTED_SIZE, 64'd2);
		flush_cfg();
		send_byte(8'hFF, 1'b1, 24'd50);
		repeat (3) send_byte(8'($urandom()), 1'b0, 24'd50);
		wait_drained();

		// largest sizes: whole buffer at the top, saturated scan limit
		queue_write(ngc_pkg::CFG_MIN_SIZE, '1);
		queue_write(ngc_pkg::CFG_MAX_SIZE, '1);
		queue_write(ngc_pkg::CFG_EXPECTED_SIZE, '1);
		queue_write(ngc_pkg::CFG_MASK_LOOSE, '1);
		flush_cfg();
		send_byte(8'h99, 1'b1, 24'h03_FFFF);
		send_byte(8'($urandom()), 1'b1, '1);
		repeat (20) send_byte(8'($urandom()), 1'b0, '1);
		wait_drained();

		// random segments, each with its own idling mix
		base = sent_items;
		for (int seg = 0; seg < 3; seg++) begin
			case (seg)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			fresh = 1'b1;
			while (sent_items < base + N_ITEMS * (seg + 1) / 3) begin
				wait_drained();
				random_cfg();
				flush_cfg();
				// hold results back long enough to back up the input
				if (fresh && seg != 1) hold_start = 1'b1;
				fresh = 1'b0;
				for (int k = 0; k < 12 && sent_items < base + N_ITEMS * (seg + 1) / 3; k++)
					random_buffer(k != 0);
			end
		end

		wait_drained();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_CYCLES * 4);
		$display("== FAIL ==");
		$finish;
	end

endmodule
